[rtl/usb_ep0_standard_request_handler_defines.svh]
// assertion macros for the control endpoint request handler
`ifndef USB_EP0_STANDARD_REQUEST_HANDLER_DEFINES_SVH
`define USB_EP0_STANDARD_REQUEST_HANDLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define USBEP0_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define USBEP0_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define USBEP0_ASSERT(label, clk, rst_n, prop, msg)
`define USBEP0_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

[rtl/usbep0_pkg.sv]
// shared types and constants of the control endpoint request handler
`timescale 1ns / 1ps

package usbep0_pkg;

    typedef enum logic [2:0] {
        ACT_ZLP     = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_STALL   = 3'd2,
        ACT_FORWARD = 3'd3,
        ACT_RESET   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        SRC_NONE   = 3'd0,
        SRC_CURCFG = 3'd1,
        SRC_DEVICE = 3'd2,
        SRC_CONFIG = 3'd3,
        SRC_STRING = 3'd4
    } t_src;

    typedef enum logic [1:0] {
        ST_DEFAULT    = 2'd0,
        ST_ADDRESS    = 2'd1,
        ST_CONFIGURED = 2'd2
    } t_dev_state;

    localparam logic OP_SETUP     = 1'b0;
    localparam logic OP_BUS_RESET = 1'b1;

    localparam logic [7:0] RT_IN_STD_DEV  = 8'h80;
    localparam logic [7:0] RT_OUT_STD_DEV = 8'h00;

    localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;

    localparam logic [7:0] DT_DEVICE = 8'd1;
    localparam logic [7:0] DT_CONFIG = 8'd2;
    localparam logic [7:0] DT_STRING = 8'd3;

    localparam logic [15:0] ADDR_MASK          = 16'h007f;
    localparam logic [15:0] DEVICE_DESC_LENGTH = 16'd18;
    localparam logic [15:0] CURCFG_LENGTH      = 16'd1;

    localparam int          APB_ADDR_W = 4;
    localparam logic [1:0]  REG_CONFIG_VALUE       = 2'd0;
    localparam logic [1:0]  REG_CONFIG_DESC_LENGTH = 2'd1;
    localparam logic [1:0]  REG_STRING_COUNT       = 2'd2;

    localparam logic [7:0] RST_CONFIG_VALUE       = 8'd1;
    localparam logic [7:0] RST_CONFIG_DESC_LENGTH = 8'd0;
    localparam logic [7:0] RST_STRING_COUNT       = 8'd0;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_in_word;

    typedef struct packed {
        t_action     action;
        t_src        data_source;
        logic [7:0]  string_number;
        logic [15:0] send_length;
        t_dev_state  device_state_out;
        logic [6:0]  device_address;
        logic [7:0]  active_configuration;
        logic        configured_event;
    } t_out_word;

    typedef struct packed {
        logic [7:0] config_value;
        logic [7:0] config_desc_length;
        logic [7:0] string_count;
    } t_cfg_regs;

    typedef struct packed {
        t_dev_state state;
        logic [6:0] address;
        logic [7:0] configuration;
    } t_dev_regs;

endpackage

[rtl/usb_ep0_standard_request_handler.sv]
// top level: input register, request decode, device state and result register
// a word taken into the input register is decoded and its result is registered in the result register once that is free
// throughput: one word per cycle while i_out_ready stays high, set by the single decode stage between the registers
// while a result waits at the output the input register takes one more word, then stalls
// reset: synchronous, active low; clears device state, address, configuration and
// both valid flags, and returns the configuration registers to their reset values
`timescale 1ns / 1ps
`include "usb_ep0_standard_request_handler_defines.svh"

module usb_ep0_standard_request_handler
    import usbep0_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cfg_regs w_cfg;
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    t_dev_regs r_dev;
    t_dev_regs w_dev_next;
    t_out_word w_result;
    logic      w_adv;
    logic      w_take;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_take     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    usbep0_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    usbep0_decode u_decode (
        .i_word     (r_in),
        .i_cfg      (w_cfg),
        .i_dev      (r_dev),
        .o_result   (w_result),
        .o_dev_next (w_dev_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_dev.state         <= ST_DEFAULT;
            r_dev.address       <= 7'd0;
            r_dev.configuration <= 8'd0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_dev       <= w_dev_next;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in_word;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    `USBEP0_ASSERT(a_cfg_nonzero, i_clk, i_rst_n,
        (r_dev.state != ST_CONFIGURED) || (r_dev.configuration != 8'd0),
        "configured state with configuration zero")
    `USBEP0_ASSERT(a_default_addr, i_clk, i_rst_n,
        (r_dev.state != ST_DEFAULT) || ((r_dev.address == 7'd0) && (r_dev.configuration == 8'd0)),
        "default state with address or configuration set")
    `USBEP0_ASSERT_NEXT(a_bus_reset, i_clk, i_rst_n,
        w_adv && (r_in.opcode == OP_BUS_RESET),
        (r_dev.state == ST_DEFAULT) && (r_out.action == ACT_RESET),
        "bus reset did not return to default state")
    `USBEP0_ASSERT(a_event_state, i_clk, i_rst_n,
        !(r_out_valid && r_out.configured_event) || (r_out.device_state_out == ST_CONFIGURED),
        "configured event outside configured state")

endmodule

[rtl/usbep0_apb_regs.sv]
// configuration registers behind the apb port
`timescale 1ns / 1ps

module usbep0_apb_regs
    import usbep0_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg_regs             o_cfg
);

    t_cfg_regs  r_cfg;
    t_cfg_regs  n_cfg;
    logic [1:0] w_index;
    logic       w_write;

    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                REG_CONFIG_VALUE:       n_cfg.config_value       = pwdata[7:0];
                REG_CONFIG_DESC_LENGTH: n_cfg.config_desc_length = pwdata[7:0];
                REG_STRING_COUNT:       n_cfg.string_count       = pwdata[7:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_CONFIG_VALUE:       prdata = {24'd0, r_cfg.config_value};
            REG_CONFIG_DESC_LENGTH: prdata = {24'd0, r_cfg.config_desc_length};
            REG_STRING_COUNT:       prdata = {24'd0, r_cfg.string_count};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.config_value       <= RST_CONFIG_VALUE;
            r_cfg.config_desc_length <= RST_CONFIG_DESC_LENGTH;
            r_cfg.string_count       <= RST_STRING_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[rtl/usbep0_decode.sv]
// standard request decode and device state update for one word
`timescale 1ns / 1ps

module usbep0_decode
    import usbep0_pkg::*;
(
    input  t_in_word  i_word,
    input  t_cfg_regs i_cfg,
    input  t_dev_regs i_dev,
    output t_out_word o_result,
    output t_dev_regs o_dev_next
);

    function automatic logic [15:0] clip_len(input logic [15:0] have, input logic [15:0] wanted);
        clip_len = (have < wanted) ? have : wanted;
    endfunction

    logic [7:0] w_hi;
    logic [7:0] w_lo;
    logic [6:0] w_addr;
    logic       w_in_std;
    logic       w_out_std;
    t_action    w_action;
    t_src       w_src;
    logic [7:0] w_strnum;
    logic [15:0] w_slen;
    logic       w_event;
    t_dev_regs  w_dev;

    assign w_hi      = i_word.request_value[15:8];
    assign w_lo      = i_word.request_value[7:0];
    assign w_addr    = 7'(i_word.request_value & ADDR_MASK);
    assign w_in_std  = (i_word.request_type == RT_IN_STD_DEV);
    assign w_out_std = (i_word.request_type == RT_OUT_STD_DEV);

    always_comb begin
        w_action = ACT_FORWARD;
        w_src    = SRC_NONE;
        w_strnum = 8'd0;
        w_slen   = 16'd0;
        w_event  = 1'b0;
        w_dev    = i_dev;
        if (i_word.opcode == OP_BUS_RESET) begin
            w_dev.state         = ST_DEFAULT;
            w_dev.address       = 7'd0;
            w_dev.configuration = 8'd0;
            w_action            = ACT_RESET;
        end else if (i_word.request_code == RQ_GET_CONFIGURATION && w_in_std) begin
            if (i_dev.state inside {ST_ADDRESS, ST_CONFIGURED}) begin
                w_action = ACT_SEND;
                w_src    = SRC_CURCFG;
                w_slen   = clip_len(CURCFG_LENGTH, i_word.request_length);
            end
        end else if (i_word.request_code == RQ_GET_DESCRIPTOR && w_in_std) begin
            if (w_hi == DT_DEVICE) begin
                w_action = ACT_SEND;
                w_src    = SRC_DEVICE;
                w_slen   = clip_len(DEVICE_DESC_LENGTH, i_word.request_length);
            end else if (w_hi == DT_CONFIG && w_lo == 8'd0) begin
                w_action = ACT_SEND;
                w_src    = SRC_CONFIG;
                w_slen   = clip_len({8'd0, i_cfg.config_desc_length}, i_word.request_length);
            end else if (w_hi == DT_STRING && w_lo < i_cfg.string_count) begin
                w_action = ACT_SEND;
                w_src    = SRC_STRING;
                w_strnum = w_lo;
                w_slen   = i_word.request_length;
            end
        end else if (i_word.request_code == RQ_SET_ADDRESS && w_out_std) begin
            if (i_dev.state inside {ST_DEFAULT, ST_ADDRESS}) begin
                w_dev.address = w_addr;
                w_dev.state   = (w_addr != 7'd0) ? ST_ADDRESS : ST_DEFAULT;
                w_action      = ACT_ZLP;
            end
        end else if (i_word.request_code == RQ_SET_CONFIGURATION && w_out_std) begin
            if (i_dev.state inside {ST_ADDRESS, ST_CONFIGURED}) begin
                if (w_lo == 8'd0) begin
                    w_dev.state         = ST_ADDRESS;
                    w_dev.configuration = 8'd0;
                    w_action            = ACT_ZLP;
                end else if (w_lo == i_cfg.config_value) begin
                    w_dev.state         = ST_CONFIGURED;
                    w_dev.configuration = w_lo;
                    w_event             = 1'b1;
                    w_action            = ACT_ZLP;
                end
            end
        end
    end

    assign o_dev_next = w_dev;

    always_comb begin
        o_result.action               = w_action;
        o_result.data_source          = w_src;
        o_result.string_number        = w_strnum;
        o_result.send_length          = w_slen;
        o_result.device_state_out     = w_dev.state;
        o_result.device_address       = w_dev.address;
        o_result.active_configuration = w_dev.configuration;
        o_result.configured_event     = w_event;
    end

endmodule

[tb/usb_ep0_standard_request_handler_test.sv]
// self-checking testbench for the control endpoint standard request handler
`timescale 1ns / 1ps

module usb_ep0_standard_request_handler_test;
    import usbep0_pkg::*;

    class ep0_tracker;
        logic [7:0] cfg_value    = RST_CONFIG_VALUE;
        logic [7:0] cfg_desc_len = RST_CONFIG_DESC_LENGTH;
        logic [7:0] str_count    = RST_STRING_COUNT;
        t_dev_state dev_st       = ST_DEFAULT;
        logic [6:0] dev_addr     = '0;
        logic [7:0] cur_cfg      = '0;
        t_out_word  want_answers[$];
        int         fails        = 0;

        task report(string msg);
            fails++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                REG_CONFIG_VALUE:       cfg_value = val;
                REG_CONFIG_DESC_LENGTH: cfg_desc_len = val;
                REG_STRING_COUNT:       str_count = val;
                default: ;
            endcase
        endfunction

        function logic [15:0] clip(logic [15:0] have, logic [15:0] wanted);
            return (have < wanted) ? have : wanted;
        endfunction

        // next device state and the answer this request earns
        function void note_request(t_in_word w);
            t_out_word  a;
            logic [7:0] hi;
            logic [7:0] lo;
            logic [15:0] masked;
            hi = w.request_value[15:8];
            lo = w.request_value[7:0];
            a = '0;
            a.action = ACT_FORWARD;
            a.data_source = SRC_NONE;
            if (w.opcode == OP_BUS_RESET) begin
                dev_st = ST_DEFAULT;
                cur_cfg = '0;
                dev_addr = '0;
                a.action = ACT_RESET;
            end else if (w.request_code == RQ_GET_CONFIGURATION &&
                         w.request_type == RT_IN_STD_DEV) begin
                if (dev_st == ST_ADDRESS || dev_st == ST_CONFIGURED) begin
                    a.action = ACT_SEND;
                    a.data_source = SRC_CURCFG;
                    a.send_length = clip(CURCFG_LENGTH, w.request_length);
                end
            end else if (w.request_code == RQ_GET_DESCRIPTOR &&
                         w.request_type == RT_IN_STD_DEV) begin
                if (hi == DT_DEVICE) begin
                    a.action = ACT_SEND;
                    a.data_source = SRC_DEVICE;
                    a.send_length = clip(DEVICE_DESC_LENGTH, w.request_length);
                end else if (hi == DT_CONFIG && lo == 8'd0) begin
                    a.action = ACT_SEND;
                    a.data_source = SRC_CONFIG;
                    a.send_length = clip({8'd0, cfg_desc_len}, w.request_length);
                end else if (hi == DT_STRING && lo < str_count) begin
                    a.action = ACT_SEND;
                    a.data_source = SRC_STRING;
                    a.string_number = lo;
                    a.send_length = w.request_length;
                end
            end else if (w.request_code == RQ_SET_ADDRESS &&
                         w.request_type == RT_OUT_STD_DEV) begin
                if (dev_st == ST_DEFAULT || dev_st == ST_ADDRESS) begin
                    masked = w.request_value & ADDR_MASK;
                    dev_addr = masked[6:0];
                    dev_st = (dev_addr != '0) ? ST_ADDRESS : ST_DEFAULT;
                    a.action = ACT_ZLP;
                end
            end else if (w.request_code == RQ_SET_CONFIGURATION &&
                         w.request_type == RT_OUT_STD_DEV) begin
                if (dev_st == ST_ADDRESS || dev_st == ST_CONFIGURED) begin
                    if (lo == 8'd0) begin
                        dev_st = ST_ADDRESS;
                        cur_cfg = '0;
                        a.action = ACT_ZLP;
                    end else if (lo == cfg_value) begin
                        dev_st = ST_CONFIGURED;
                        cur_cfg = lo;
                        a.configured_event = 1'b1;
                        a.action = ACT_ZLP;
                    end
                end
            end
            a.device_state_out = dev_st;
            a.device_address = dev_addr;
            a.active_configuration = cur_cfg;
            want_answers.push_back(a);
        endfunction

        task cmp(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (want_answers.size() == 0) begin
                report("result word with no request outstanding");
            end else begin
                want = want_answers.pop_front();
                cmp("action", got.action, want.action);
                cmp("data_source", got.data_source, want.data_source);
                cmp("string_number", got.string_number, want.string_number);
                cmp("send_length", got.send_length, want.send_length);
                cmp("device_state_out", got.device_state_out, want.device_state_out);
                cmp("device_address", got.device_address, want.device_address);
                cmp("active_configuration", got.active_configuration,
                    want.active_configuration);
                cmp("configured_event", got.configured_event, want.configured_event);
            end
        endtask

        function int pending();
            return want_answers.size();
        endfunction

        task finish();
            if (want_answers.size() != 0) begin
                report($sformatf("%0d results never arrived", want_answers.size()));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    ep0_tracker sb = new();
    int         in_idle_pct  = 15;
    int         out_idle_pct = 57;
    bit         hold_req     = 1'b0;
    int         hold_left    = 0;

    usb_ep0_standard_request_handler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_word);
        end
    end

    // result side: random backpressure plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 59;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    function automatic t_in_word mk(logic op, logic [7:0] rt, logic [7:0] rc,
                                    logic [15:0] val, logic [15:0] idx, logic [15:0] len);
        t_in_word w;
        w.opcode = op;
        w.request_type = rt;
        w.request_code = rc;
        w.request_value = val;
        w.request_index = idx;
        w.request_length = len;
        return w;
    endfunction

    function automatic logic [15:0] rand_len();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(20));
            3:       return 16'($urandom_range(300));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed standard requests, some bus resets, some with a bent request type, some noise
    function automatic t_in_word rand_request();
        t_in_word   w;
        int         k;
        logic [7:0] lo;
        logic [7:0] hi;
        w = mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, 16'($urandom),
               16'($urandom), rand_len());
        hi = 8'($urandom);
        lo = 8'($urandom);
        k = $urandom_range(99);
        if (k < 5) begin
            w.opcode = OP_BUS_RESET;
            w.request_type = 8'($urandom);
            w.request_code = 8'($urandom);
        end else if (k < 20) begin
            w.request_value = {DT_DEVICE, lo};
        end else if (k < 32) begin
            w.request_value = {DT_CONFIG, ($urandom_range(3) == 0) ? lo : 8'd0};
        end else if (k < 44) begin
            if ($urandom_range(1) == 0) begin
                lo = 8'($urandom_range(int'(sb.str_count) + 2));
            end
            w.request_value = {DT_STRING, lo};
        end else if (k < 54) begin
            w.request_code = RQ_GET_CONFIGURATION;
        end else if (k < 68) begin
            w.request_type = RT_OUT_STD_DEV;
            w.request_code = RQ_SET_ADDRESS;
            if ($urandom_range(7) == 0) begin
                w.request_value = {hi, 8'd0};
            end
        end else if (k < 82) begin
            w.request_type = RT_OUT_STD_DEV;
            w.request_code = RQ_SET_CONFIGURATION;
            case ($urandom_range(2))
                0:       lo = 8'd0;
                1:       lo = sb.cfg_value;
                default: ;
            endcase
            w.request_value = {hi, lo};
        end else if (k < 90) begin
            case ($urandom_range(3))
                0: w.request_code = RQ_GET_CONFIGURATION;
                1: w.request_code = RQ_GET_DESCRIPTOR;
                2: w.request_code = RQ_SET_ADDRESS;
                default: w.request_code = RQ_SET_CONFIGURATION;
            endcase
            if (w.request_code == RQ_SET_ADDRESS || w.request_code == RQ_SET_CONFIGURATION) begin
                w.request_type = RT_OUT_STD_DEV;
            end
            w.request_type[$urandom_range(7)] ^= 1'b1;
        end else begin
            w = t_in_word'({$urandom, $urandom, $urandom});
        end
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word = w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(w);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [7:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = APB_ADDR_W'({idx, 2'b00});
        pwdata = {24'd0, val};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_regs(logic [7:0] cv, logic [7:0] cdl, logic [7:0] sc);
        apb_write(REG_CONFIG_VALUE, cv);
        apb_write(REG_CONFIG_DESC_LENGTH, cdl);
        apb_write(REG_STRING_COUNT, sc);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_random(int n, bit pressure);
        for (int i = 0; i < n; i++) begin
            if (pressure && i == n / 3) begin
                hold_req = 1'b1;
            end
            send_word(rand_request());
        end
    endtask

    task automatic run_directed();
        send_word(mk(OP_BUS_RESET, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00},
                     16'h0000, 16'hffff));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'hff},
                     16'hffff, 16'h0000));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_CONFIGURATION, 16'h0000,
                     16'h0000, 16'h0001));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_CONFIGURATION, 16'h0003,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00},
                     16'h0000, 16'hffff));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00},
                     16'h0000, 16'd10));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h01},
                     16'h0000, 16'hffff));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_STRING, 8'h00},
                     16'h0409, 16'h0040));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_STRING, 8'h03},
                     16'h0409, 16'hffff));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, {DT_STRING, 8'h04},
                     16'h0409, 16'hffff));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_DESCRIPTOR, 16'h0600,
                     16'h0000, 16'h000a));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00},
                     16'h0000, 16'h0012));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_ADDRESS, 16'hff7f,
                     16'hffff, 16'h0000));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_ADDRESS, 16'h0000,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_ADDRESS, 16'h0005,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_CONFIGURATION, 16'h0000,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_CONFIGURATION, 16'h0000,
                     16'h0000, 16'hffff));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_CONFIGURATION, 16'h0002,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_CONFIGURATION, 16'hff03,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_ADDRESS, 16'h0009,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, RT_IN_STD_DEV, RQ_GET_CONFIGURATION, 16'h0000,
                     16'h0000, 16'h0001));
        send_word(mk(OP_SETUP, RT_OUT_STD_DEV, RQ_SET_CONFIGURATION, 16'h0000,
                     16'h0000, 16'h0000));
        send_word(mk(OP_SETUP, 8'h80, 8'h00, 16'h0000, 16'hffff, 16'h0002));
        send_word(mk(OP_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000));
    endtask

    initial begin
        int waited;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_regs(8'd3, 8'd34, 8'd4);
        run_directed();
        drain();

        set_regs(8'd255, 8'd255, 8'd255);
        run_random(200, 1'b1);
        drain();

        in_idle_pct = 57;
        out_idle_pct = 15;
        set_regs(8'd1, 8'd0, 8'd0);
        run_random(200, 1'b1);
        drain();

        in_idle_pct = 0;
        out_idle_pct = 0;
        set_regs(8'($urandom_range(1, 8)), 8'($urandom), 8'($urandom_range(1, 16)));
        run_random(200, 1'b0);

        i_in_valid = 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);
        sb.finish();
        if (sb.fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
